FILE: rtl/ibo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibo_pkg
// Shared operation codes of the interval binary operation unit.
// ----------------------------------------------------------------------------
package ibo_pkg;

    localparam int FUNC_WIDTH = 4;

    // operation codes, codes 12 to 15 are unused
    typedef enum logic [FUNC_WIDTH-1:0] {
        FUNC_SUB = 4'd0,
        FUNC_ADD = 4'd1,
        FUNC_MUL = 4'd2,
        FUNC_DIV = 4'd3,
        FUNC_MOD = 4'd4,
        FUNC_MIN = 4'd5,
        FUNC_MAX = 4'd6,
        FUNC_AND = 4'd7,
        FUNC_OR  = 4'd8,
        FUNC_XOR = 4'd9,
        FUNC_SHL = 4'd10,
        FUNC_SHR = 4'd11
    } t_func;

endpackage

FILE: rtl/ibo_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibo_in_if / ibo_out_if
// Valid/ready channels carrying operand items and result items.
// ----------------------------------------------------------------------------
interface ibo_in_if
    import ibo_pkg::*;
#(
    parameter int BOUND_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [FUNC_WIDTH-1:0]         func;
    logic signed [BOUND_WIDTH-1:0] left_low;
    logic signed [BOUND_WIDTH-1:0] left_high;
    logic signed [BOUND_WIDTH-1:0] right_low;
    logic signed [BOUND_WIDTH-1:0] right_high;

    modport source (output valid, func, left_low, left_high, right_low, right_high,
                    input ready);
    modport sink   (input valid, func, left_low, left_high, right_low, right_high,
                    output ready);
endinterface

interface ibo_out_if #(
    parameter int BOUND_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [BOUND_WIDTH-1:0] result_low;
    logic signed [BOUND_WIDTH-1:0] result_high;
    logic                          saturated;
    logic                          op_invalid;

    modport source (output valid, result_low, result_high, saturated, op_invalid,
                    input ready);
    modport sink   (input valid, result_low, result_high, saturated, op_invalid,
                    output ready);
endinterface

FILE: rtl/ibo_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibo_div_lane
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ibo_div_lane #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic [WIDTH-1:0] o_quotient
);

    logic [WIDTH-1:0] r_rem [WIDTH];
    logic [WIDTH-1:0] r_quo [WIDTH];
    logic [WIDTH-1:0] r_dvd [WIDTH];
    logic [WIDTH-1:0] r_dvs [WIDTH];
    logic [WIDTH-1:0] n_rem [WIDTH];
    logic [WIDTH-1:0] n_quo [WIDTH];

    // one trial subtraction per stage, each stage after the first works on the registers of the stage before it
    always_comb begin
        logic [WIDTH-1:0] p_rem;
        logic [WIDTH-1:0] p_quo;
        logic [WIDTH-1:0] p_dvd;
        logic [WIDTH-1:0] p_dvs;
        logic [WIDTH:0]   trial;
        for (int s = 0; s < WIDTH; s++) begin
            p_rem = (s == 0) ? '0 : r_rem[(s == 0) ? 0 : s-1];
            p_quo = (s == 0) ? '0 : r_quo[(s == 0) ? 0 : s-1];
            p_dvd = (s == 0) ? i_dividend : r_dvd[(s == 0) ? 0 : s-1];
            p_dvs = (s == 0) ? i_divisor  : r_dvs[(s == 0) ? 0 : s-1];
            trial = {p_rem, p_dvd[WIDTH-1-s]};
            if (trial >= {1'b0, p_dvs}) begin
                n_rem[s] = WIDTH'(trial - {1'b0, p_dvs});
                n_quo[s] = {p_quo[WIDTH-2:0], 1'b1};
            end else begin
                n_rem[s] = trial[WIDTH-1:0];
                n_quo[s] = {p_quo[WIDTH-2:0], 1'b0};
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < WIDTH; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_dvd[s] <= (s == 0) ? i_dividend : r_dvd[(s == 0) ? 0 : s-1];
                r_dvs[s] <= (s == 0) ? i_divisor  : r_dvs[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign o_quotient = r_quo[WIDTH-1];

endmodule

FILE: rtl/interval_binary_op_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_binary_op_unit
// Interval arithmetic on signed bounds with saturation to the bound range.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the output item is not held waiting. The path
// is BOUND_WIDTH + 3 registers: the input register, a BOUND_WIDTH-stage divider
// pipeline with one quotient bit per stage whose first stage also captures the
// products and the results of the other operations, a corner min/max stage and
// a saturating output register. All operations share the same latency, so
// results leave in input order. The pipeline stalls as a whole when the output
// item is not taken; the input is ready whenever the output register is empty
// or being taken.
module interval_binary_op_unit
    import ibo_pkg::*;
#(
    parameter int BOUND_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ibo_in_if.sink    i_req,
    ibo_out_if.source o_rsp
);

    localparam int W  = BOUND_WIDTH;
    localparam int X  = 2 * W + 1;
    localparam int SW = $clog2(W);

    typedef logic signed [W-1:0] t_bnd;
    typedef logic signed [X-1:0] t_wide;

    localparam t_wide MAXX = t_wide'((t_wide'(1) <<< (W - 1)) - t_wide'(1));
    localparam t_wide MINX = t_wide'(-(t_wide'(1) <<< (W - 1)));

    function automatic logic [W-1:0] mag_w(input t_bnd v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic logic [SW-1:0] shcount(input t_bnd c);
        if (c[W-1])                    return '0;
        else if (c > t_bnd'(W - 1))    return SW'(W - 1);
        else                           return c[SW-1:0];
    endfunction

    function automatic t_wide min2(input t_wide a, input t_wide b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_wide max2(input t_wide a, input t_wide b);
        return (a > b) ? a : b;
    endfunction

    logic en;

    // input stage
    logic           r0_v;
    logic [3:0]     r0_func;
    t_bnd           r0_ll, r0_lh, r0_rl, r0_rh;

    // output register
    logic           r_out_v;
    t_bnd           r_out_lo, r_out_hi;
    logic           r_out_sat, r_out_inv;

    assign en          = !r_out_v || o_rsp.ready;
    assign i_req.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_func <= i_req.func;
            r0_ll   <= i_req.left_low;
            r0_lh   <= i_req.left_high;
            r0_rl   <= i_req.right_low;
            r0_rh   <= i_req.right_high;
        end
    end

    // multiply stage and the other operations
    t_wide          n_c [4];
    logic [3:0]     n_qneg;
    logic [W-1:0]   dvd [4];
    logic [W-1:0]   dvs [4];

    always_comb begin
        t_wide                 ll, lh, rl, rh, m, lo, hi;
        t_wide                 k;
        logic signed [2*W-1:0] p0, p1, p2, p3;
        logic [W-1:0]          ma, mb, mmax, kw;
        t_bnd                  dl, dh;
        ll = t_wide'(r0_ll);
        lh = t_wide'(r0_lh);
        rl = t_wide'(r0_rl);
        rh = t_wide'(r0_rh);
        p0 = r0_ll * r0_rl;
        p1 = r0_ll * r0_rh;
        p2 = r0_lh * r0_rl;
        p3 = r0_lh * r0_rh;

        // largest magnitude and its all-ones mask
        ma   = (mag_w(r0_ll) > mag_w(r0_lh)) ? mag_w(r0_ll) : mag_w(r0_lh);
        mb   = (mag_w(r0_rl) > mag_w(r0_rh)) ? mag_w(r0_rl) : mag_w(r0_rh);
        mmax = (ma > mb) ? ma : mb;
        for (int i = 0; i < W; i++) begin
            kw[i] = |(mmax >> i);
        end
        k = t_wide'({1'b0, kw});

        // mod clamp magnitude
        m = t_wide'({1'b0, mb});

        // divisors with zero bounds replaced
        dl = (r0_rl == '0) ? t_bnd'(1)  : r0_rl;
        dh = (r0_rh == '0) ? t_bnd'(-1) : r0_rh;
        dvd[0] = mag_w(r0_ll); dvs[0] = mag_w(dl);
        dvd[1] = mag_w(r0_ll); dvs[1] = mag_w(dh);
        dvd[2] = mag_w(r0_lh); dvs[2] = mag_w(dl);
        dvd[3] = mag_w(r0_lh); dvs[3] = mag_w(dh);
        n_qneg = {r0_lh[W-1] ^ dh[W-1], r0_lh[W-1] ^ dl[W-1],
                  r0_ll[W-1] ^ dh[W-1], r0_ll[W-1] ^ dl[W-1]};

        lo = '0;
        hi = '0;
        n_c[2] = '0;
        n_c[3] = '0;
        case (t_func'(r0_func))
            FUNC_SUB: begin
                lo = ll - rh;
                hi = lh - rl;
            end
            FUNC_ADD: begin
                lo = ll + rl;
                hi = lh + rh;
            end
            FUNC_MUL: begin
                lo     = t_wide'(p0);
                hi     = t_wide'(p1);
                n_c[2] = t_wide'(p2);
                n_c[3] = t_wide'(p3);
            end
            FUNC_MOD: begin
                lo = min2(((ll < 0) && (-ll > m)) ? -m : ll, '0);
                hi = max2(((lh > 0) && (lh > m)) ? m : lh, '0);
            end
            FUNC_MIN: begin
                lo = min2(ll, rl);
                hi = min2(lh, rh);
            end
            FUNC_MAX: begin
                lo = max2(ll, rl);
                hi = max2(lh, rh);
            end
            FUNC_AND: begin
                lo = (r0_ll[W-1] && r0_rl[W-1])   ? -k : '0;
                hi = (!r0_ll[W-1] || !r0_rl[W-1]) ? k  : '0;
            end
            FUNC_OR: begin
                lo = (r0_ll[W-1] || r0_rl[W-1])   ? -k : '0;
                hi = (!r0_ll[W-1] && !r0_rl[W-1]) ? k  : '0;
            end
            FUNC_XOR: begin
                lo = (r0_ll[W-1] || r0_rl[W-1])   ? -k : '0;
                hi = (!r0_ll[W-1] || !r0_rl[W-1]) ? k  : '0;
            end
            FUNC_SHL: begin
                lo = ll <<< shcount(r0_rl);
                hi = lh <<< shcount(r0_rh);
            end
            FUNC_SHR: begin
                lo = t_wide'(r0_ll >>> shcount(r0_rh));
                hi = t_wide'(r0_lh >>> shcount(r0_rl));
            end
            default: begin
                lo = '0;
                hi = '0;
            end
        endcase
        n_c[0] = lo;
        n_c[1] = hi;
    end

    // divider lanes, one per corner quotient
    logic [W-1:0] quo [4];

    for (genvar g = 0; g < 4; g++) begin : g_div
        ibo_div_lane #(
            .WIDTH (W)
        ) u_div (
            .i_clk      (i_clk),
            .i_en       (en),
            .i_dividend (dvd[g]),
            .i_divisor  (dvs[g]),
            .o_quotient (quo[g])
        );
    end

    // delay line alongside the divider
    logic       r_d_v    [W];
    logic [3:0] r_d_func [W];
    logic [3:0] r_d_qneg [W];
    t_wide      r_d_c    [W][4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < W; s++) begin
                r_d_v[s] <= 1'b0;
            end
        end else if (en) begin
            for (int s = 0; s < W; s++) begin
                r_d_v[s] <= (s == 0) ? r0_v : r_d_v[(s == 0) ? 0 : s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < W; s++) begin
                r_d_func[s] <= (s == 0) ? r0_func : r_d_func[(s == 0) ? 0 : s-1];
                r_d_qneg[s] <= (s == 0) ? n_qneg  : r_d_qneg[(s == 0) ? 0 : s-1];
                for (int j = 0; j < 4; j++) begin
                    r_d_c[s][j] <= (s == 0) ? n_c[j] : r_d_c[(s == 0) ? 0 : s-1][j];
                end
            end
        end
    end

    // corner min/max and operation select
    logic  rc_v, rc_inv;
    t_wide rc_lo, rc_hi;
    t_wide n_lo, n_hi;
    logic  n_inv;

    always_comb begin
        t_wide q [4];
        for (int j = 0; j < 4; j++) begin
            q[j] = r_d_qneg[W-1][j] ? -t_wide'({1'b0, quo[j]}) : t_wide'({1'b0, quo[j]});
        end
        n_inv = 1'b0;
        case (t_func'(r_d_func[W-1]))
            FUNC_MUL: begin
                n_lo = min2(min2(r_d_c[W-1][0], r_d_c[W-1][1]),
                            min2(r_d_c[W-1][2], r_d_c[W-1][3]));
                n_hi = max2(max2(r_d_c[W-1][0], r_d_c[W-1][1]),
                            max2(r_d_c[W-1][2], r_d_c[W-1][3]));
            end
            FUNC_DIV: begin
                n_lo = min2(min2(q[0], q[1]), min2(q[2], q[3]));
                n_hi = max2(max2(q[0], q[1]), max2(q[2], q[3]));
            end
            FUNC_SUB, FUNC_ADD, FUNC_MOD, FUNC_MIN, FUNC_MAX, FUNC_AND,
            FUNC_OR, FUNC_XOR, FUNC_SHL, FUNC_SHR: begin
                n_lo = r_d_c[W-1][0];
                n_hi = r_d_c[W-1][1];
            end
            default: begin
                n_lo  = '0;
                n_hi  = '0;
                n_inv = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc_v <= 1'b0;
        end else if (en) begin
            rc_v <= r_d_v[W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rc_lo  <= n_lo;
            rc_hi  <= n_hi;
            rc_inv <= n_inv;
        end
    end

    // saturation into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= rc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_lo  <= (rc_lo > MAXX) ? MAXX[W-1:0] :
                         (rc_lo < MINX) ? MINX[W-1:0] : rc_lo[W-1:0];
            r_out_hi  <= (rc_hi > MAXX) ? MAXX[W-1:0] :
                         (rc_hi < MINX) ? MINX[W-1:0] : rc_hi[W-1:0];
            r_out_sat <= (rc_lo > MAXX) || (rc_lo < MINX) ||
                         (rc_hi > MAXX) || (rc_hi < MINX);
            r_out_inv <= rc_inv;
        end
    end

    assign o_rsp.valid       = r_out_v;
    assign o_rsp.result_low  = r_out_lo;
    assign o_rsp.result_high = r_out_hi;
    assign o_rsp.saturated   = r_out_sat;
    assign o_rsp.op_invalid  = r_out_inv;

    // unused opcodes give a zero interval and no saturation
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.op_invalid |->
            (o_rsp.result_low == '0) && (o_rsp.result_high == '0) && !o_rsp.saturated)
        else $error("invalid opcode item carries nonzero result");

    // a saturated item has a bound at one end of the range
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.saturated |->
            (o_rsp.result_low == MAXX[W-1:0]) || (o_rsp.result_low == MINX[W-1:0]) ||
            (o_rsp.result_high == MAXX[W-1:0]) || (o_rsp.result_high == MINX[W-1:0]))
        else $error("saturated flag without a clamped bound");

    // the input only stalls behind a waiting result item
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> o_rsp.valid && !o_rsp.ready)
        else $error("input stalled with no result waiting");

endmodule
